// File: sv/psrl_pkg.sv
// Package for the per-source rate limiter: table constants, entry type, verdict codes.
// No dependencies.
package psrl_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [31:0] RECENT_WINDOW = 32'd60;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam logic [1:0] CSR_RATE_LIMIT = 2'd0;
   localparam logic [1:0] CSR_BAN_LEVEL = 2'd1;
   localparam logic [1:0] CSR_BAN_SECONDS = 2'd2;
   localparam logic [1:0] CSR_TRACKED_LIMIT = 2'd3;

   localparam logic OP_CHECK = 1'b0;
   localparam logic OP_CLEANUP = 1'b1;

   localparam logic [2:0] VERDICT_ALLOWED = 3'd0;
   localparam logic [2:0] VERDICT_FULL = 3'd1;
   localparam logic [2:0] VERDICT_BANNED = 3'd2;
   localparam logic [2:0] VERDICT_OVER_RATE = 3'd3;
   localparam logic [2:0] VERDICT_BAN_START = 3'd4;
   localparam logic [2:0] VERDICT_CLEANUP = 3'd5;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] seen_sec;
      logic [15:0] count;
      logic [31:0] ban_expiry;
   } entry_type;

   // Control from the sequencer to every cell.
   typedef struct packed {
      logic shift;     // rotate the ring by one position
      logic load;      // replace the cell at the ring head with new data
      logic drop;      // head dropped: only cells above the sweep point move
   } cell_ctl_type;

endpackage

// File: sv/psrl_cell.sv
// One table cell of the rotating entry ring.
// Depends on psrl_pkg.
module psrl_cell (
   input  logic                  clock,
   input  psrl_pkg::cell_ctl_type ctl,
   input  psrl_pkg::entry_type   prev_entry,
   input  psrl_pkg::entry_type   load_entry,
   input  logic                  is_head,
   input  logic                  above,
   output psrl_pkg::entry_type   entry
);
   import psrl_pkg::*;

   entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.load && is_head) begin
         entry_in = load_entry;
      end else if (ctl.shift || (ctl.drop && above)) begin
         entry_in = prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: sv/psrl_ctl.sv
// Sequencer of the rate limiter: walks the cell ring for search and compaction.
// Depends on psrl_pkg.
module psrl_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_op,
   input  logic [31:0]           req_ip_key,
   input  logic [31:0]           req_now_seconds,
   input  logic [15:0]           rate_limit,
   input  logic [15:0]           ban_level,
   input  logic [31:0]           ban_seconds,
   input  logic [6:0]            tracked_limit,
   input  psrl_pkg::entry_type   head_entry,
   output psrl_pkg::cell_ctl_type ctl,
   output psrl_pkg::entry_type   load_entry,
   output logic [psrl_pkg::CNT_W-1:0] ring_step,
   output logic                  rsp_valid,
   output logic                  rsp_allowed,
   output logic [2:0]            rsp_verdict,
   output logic [6:0]            rsp_entries_in_use
);
   import psrl_pkg::*;

   // The ring is always rotated back to its home position. Head cell is the one
   // whose data leaves the ring; a full rotation of TABLE_DEPTH shifts returns it.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_SWEEP  = 5'b00100,
      ST_DONE   = 5'b01000,
      ST_ALIGN  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] keep_ff, keep_in;
   logic [CNT_W-1:0] hit_ff, hit_in;
   logic found_ff, found_in;
   logic [31:0] key_ff, key_in, now_ff, now_in;
   logic valid_ff, valid_in;
   logic allowed_ff, allowed_in;
   logic [2:0] verdict_ff, verdict_in;

   logic [CNT_W-1:0] limit;
   logic [31:0] age;
   logic keep_it;
   entry_type upd;
   logic [15:0] cnt;

   assign limit = (tracked_limit > 7'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                   : CNT_W'(tracked_limit);
   assign age = now_ff - head_entry.seen_sec;
   assign keep_it = (age < RECENT_WINDOW) || (head_entry.ban_expiry > now_ff);

   // Update of the entry at the head for a check.
   always_comb begin
      upd = head_entry;
      if (!found_ff) begin
         upd.key = key_ff;
         upd.seen_sec = now_ff;
         upd.count = '0;
         upd.ban_expiry = '0;
      end
      cnt = (now_ff != upd.seen_sec) ? 16'd1
          : ((upd.count != COUNT_MAX) ? upd.count + 16'd1 : upd.count);
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      used_in = used_ff;
      keep_in = keep_ff;
      hit_in = hit_ff;
      found_in = found_ff;
      key_in = key_ff;
      now_in = now_ff;
      valid_in = 1'b0;
      allowed_in = allowed_ff;
      verdict_in = verdict_ff;
      ctl = '0;
      load_entry = upd;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in = req_ip_key;
               now_in = req_now_seconds;
               step_in = '0;
               keep_in = '0;
               found_in = 1'b0;
               hit_in = '0;
               state_in = (req_op == OP_CLEANUP) ? ST_SWEEP : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // Full rotation; record first matching live slot.
            if (!found_ff && step_ff < used_ff && head_entry.key == key_ff) begin
               found_in = 1'b1;
               hit_in = step_ff;
            end
            ctl.shift = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == CNT_W'(TABLE_DEPTH - 1)) begin
               step_in = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Second rotation: update the chosen slot as it passes the head.
            if (step_ff == '0) begin
               if (!found_ff && used_ff >= limit) begin
                  valid_in = 1'b1;
                  allowed_in = 1'b0;
                  verdict_in = VERDICT_FULL;
                  state_in = ST_IDLE;
               end else if (!found_ff) begin
                  hit_in = used_ff;
               end
            end
            if (state_in == ST_DONE) begin
               ctl.shift = 1'b1;
               if (step_ff == hit_in) begin
                  ctl.load = 1'b1;
                  if (!found_ff) used_in = used_ff + 1'b1;
                  if (upd.ban_expiry > now_ff) begin
                     load_entry = upd;
                     verdict_in = VERDICT_BANNED;
                     allowed_in = 1'b0;
                  end else begin
                     load_entry = upd;
                     load_entry.count = cnt;
                     load_entry.seen_sec = now_ff;
                     if (cnt <= rate_limit) begin
                        verdict_in = VERDICT_ALLOWED;
                        allowed_in = 1'b1;
                     end else if (cnt >= ban_level) begin
                        load_entry.ban_expiry = now_ff + ban_seconds;
                        verdict_in = VERDICT_BAN_START;
                        allowed_in = 1'b0;
                     end else begin
                        verdict_in = VERDICT_OVER_RATE;
                        allowed_in = 1'b0;
                     end
                  end
               end
               step_in = step_ff + 1'b1;
               if (step_ff == CNT_W'(TABLE_DEPTH - 1)) begin
                  valid_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SWEEP: begin
            // Kept head: whole ring shifts, head queues behind earlier kept
            // entries in the low cells. Dropped head: only unvisited cells move.
            if (step_ff < used_ff && keep_it) begin
               ctl.shift = 1'b1;
               keep_in = keep_ff + 1'b1;
            end else begin
               ctl.drop = 1'b1;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == CNT_W'(TABLE_DEPTH - 1)) begin
               step_in = keep_in;
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            // TABLE_DEPTH - kept more shifts bring the kept entries home.
            if (step_ff == CNT_W'(TABLE_DEPTH)) begin
               valid_in = 1'b1;
               allowed_in = 1'b0;
               verdict_in = VERDICT_CLEANUP;
               used_in = keep_ff;
               state_in = ST_IDLE;
            end else begin
               ctl.shift = 1'b1;
               step_in = step_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         valid_ff <= valid_in;
      end
      step_ff <= step_in;
      keep_ff <= keep_in;
      hit_ff <= hit_in;
      found_ff <= found_in;
      key_ff <= key_in;
      now_ff <= now_in;
      allowed_ff <= allowed_in;
      verdict_ff <= verdict_in;
   end

   assign busy = (state_ff != ST_IDLE) || valid_ff;
   assign ring_step = step_ff;
   assign rsp_valid = valid_ff;
   assign rsp_allowed = allowed_ff;
   assign rsp_verdict = verdict_ff;
   assign rsp_entries_in_use = 7'(used_ff);

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(TABLE_DEPTH)) else $error("occupancy above depth");
   a_cleanup_no_grow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERDICT_CLEANUP |-> !rsp_allowed)
      else $error("cleanup allowed");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result");

endmodule

// File: sv/psrl_ring.sv
// Ring of table cells; when compaction drops the head, only cells above the sweep point move.
// Depends on psrl_pkg and psrl_cell.
module psrl_ring (
   input  logic                    clock,
   input  psrl_pkg::cell_ctl_type  ctl,
   input  psrl_pkg::entry_type     load_entry,
   input  logic [psrl_pkg::CNT_W-1:0] step,
   output psrl_pkg::entry_type     head_entry
);
   import psrl_pkg::*;

   entry_type cells [TABLE_DEPTH];

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      psrl_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .prev_entry (cells[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]),
         .load_entry (load_entry),
         .is_head    (i == 0),
         .above      (CNT_W'(i) > step),
         .entry      (cells[i])
      );
   end

   assign head_entry = cells[TABLE_DEPTH-1];

endmodule

// File: sv/per_source_rate_limiter_with_ban.sv
// Top level of the per-source rate limiter with ban.
// Depends on psrl_pkg, psrl_ctl and psrl_ring.
//
// The table sits in a ring of cells that rotates one entry per cycle past a
// single compare and update point, so the search and sweep walks span the ring size.
// A check makes one rotation to search, one to update the chosen slot as it
// passes the head, then gives its result; a refusal for a full table comes
// back at the start of the second rotation. A cleanup makes one rotation that
// packs the kept entries together, then TABLE_DEPTH - kept shifts to bring
// them home. Pulse start while busy is low; one word comes back on rsp_valid
// for one cycle and cannot be stalled. Table contents need no clearing after
// reset; occupancy starts at zero.
module per_source_rate_limiter_with_ban (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [31:0] req_ip_key,
   input  logic [31:0] req_now_seconds,
   output logic        rsp_valid,
   output logic        rsp_allowed,
   output logic [2:0]  rsp_verdict,
   output logic [6:0]  rsp_entries_in_use,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import psrl_pkg::*;

   logic [15:0] rate_limit_ff, ban_level_ff;
   logic [31:0] ban_seconds_ff;
   logic [6:0]  tracked_limit_ff;
   cell_ctl_type ctl;
   entry_type load_entry, head_entry;
   logic [CNT_W-1:0] ring_step;
   logic go;

   assign go = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_limit_ff <= 16'd10;
         ban_level_ff <= 16'd20;
         ban_seconds_ff <= 32'd300;
         tracked_limit_ff <= 7'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RATE_LIMIT:    rate_limit_ff <= csr_wdata[15:0];
            CSR_BAN_LEVEL:     ban_level_ff <= csr_wdata[15:0];
            CSR_BAN_SECONDS:   ban_seconds_ff <= csr_wdata;
            CSR_TRACKED_LIMIT: tracked_limit_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   psrl_ctl u_ctl (
      .clock(clock), .reset(reset), .start(go), .busy(busy),
      .req_op(req_op), .req_ip_key(req_ip_key), .req_now_seconds(req_now_seconds),
      .rate_limit(rate_limit_ff), .ban_level(ban_level_ff),
      .ban_seconds(ban_seconds_ff), .tracked_limit(tracked_limit_ff),
      .head_entry(head_entry), .ctl(ctl), .load_entry(load_entry),
      .ring_step(ring_step),
      .rsp_valid(rsp_valid), .rsp_allowed(rsp_allowed), .rsp_verdict(rsp_verdict),
      .rsp_entries_in_use(rsp_entries_in_use)
   );

   psrl_ring u_ring (
      .clock(clock), .ctl(ctl), .load_entry(load_entry),
      .step(ring_step), .head_entry(head_entry)
   );

endmodule
